/* rtl/tpf_pkg.sv */
`default_nettype none

package tpf_pkg;

    localparam int TPF_QUEUE_DEPTH = 2;

    localparam int ADDR_W = 14;
    localparam int TILE_BASE_W = 13;

    localparam logic [ADDR_W-1:0] MAP_BASE_LOW  = 14'h1800;
    localparam logic [ADDR_W-1:0] MAP_BASE_HIGH = 14'h1C00;
    localparam logic [ADDR_W-1:0] BANK_OFFSET   = 14'h2000;
    localparam logic [TILE_BASE_W-1:0] SIGNED_BASE = 13'h1000;
    localparam logic [2:0] LINE_MASK = 3'h7;

    // attribute byte bit positions
    localparam int ATTR_BANK_BIT  = 3;
    localparam int ATTR_HFLIP_BIT = 5;
    localparam int ATTR_VFLIP_BIT = 6;

    // configuration register indexes
    localparam logic CFG_COLOUR_MODE        = 1'b0;
    localparam logic CFG_UNSIGNED_TILE_DATA = 1'b1;

    typedef enum logic {
        K_WRITE  = 1'b0,
        K_RENDER = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;   // write address, or map address for renders
        logic [7:0]        data;
        logic [4:0]        col;
        logic [4:0]        row;
        logic [2:0]        line;
    } t_op;

    typedef struct packed {
        logic colour_mode;
        logic unsigned_tile_data;
    } t_cfg;

endpackage

`default_nettype wire

/* rtl/tpf_front.sv */
`default_nettype none

module tpf_front
    import tpf_pkg::*;
(
    input  wire logic        start,
    input  wire logic        i_cmd,
    input  wire logic [13:0] i_mem_address,
    input  wire logic [7:0]  i_mem_data,
    input  wire logic        i_map_select,
    input  wire logic [4:0]  i_tile_column,
    input  wire logic [4:0]  i_tile_row,
    input  wire logic [2:0]  i_tile_line,
    input  wire logic        i_queue_full,
    output logic             busy,
    output logic             o_push,
    output t_op              o_op
);

    logic [ADDR_W-1:0] map_base;

    assign busy   = i_queue_full;
    assign o_push = start && !i_queue_full;

    always_comb begin
        map_base = i_map_select ? MAP_BASE_HIGH : MAP_BASE_LOW;
        o_op.kind = t_kind'(i_cmd);
        o_op.data = i_mem_data;
        o_op.col  = i_tile_column;
        o_op.row  = i_tile_row;
        o_op.line = i_tile_line;
        unique case (t_kind'(i_cmd))
            K_WRITE:  o_op.addr = i_mem_address;
            // map entry offset is row*32 + col, below the base's set bits
            K_RENDER: o_op.addr = map_base | {4'b0, i_tile_row, i_tile_column};
            default:  o_op.addr = i_mem_address;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/tpf_queue.sv */
`default_nettype none

module tpf_queue
    import tpf_pkg::*;
#(
    parameter int DEPTH = TPF_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    input  wire logic i_pop,
    output t_op       o_op,
    output logic      o_full,
    output logic      o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(DEPTH - 1)) q = '0;
        else                        q = p + PTR_W'(1);
        return q;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop)      n_count = r_count + CNT_W'(1);
        else if (!i_push && i_pop) n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_op;
    end

endmodule

`default_nettype wire

/* rtl/tpf_back.sv */
`default_nettype none

module tpf_back
    import tpf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire t_op        i_op,
    input  wire logic       i_empty,
    output logic            o_pop,
    output logic            o_valid,
    output logic [7:0]      o_pixel_x,
    output logic [7:0]      o_pixel_y,
    output logic [1:0]      o_colour_index,
    output logic [2:0]      o_palette_number,
    output logic            o_last_pixel
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TILE,
        S_PIX
    } t_state;

    localparam int VRAM_DEPTH = 1 << ADDR_W;

    t_state            r_state;
    t_op               r_op;
    logic [7:0]        r_vram [VRAM_DEPTH];
    logic [7:0]        r_rd_a, r_rd_b;
    logic [7:0]        r_attr;
    logic [2:0]        r_px;

    logic              mem_we;
    logic              rd_en;
    logic [ADDR_W-1:0] ra_a, ra_b;
    logic [7:0]        attr;
    logic [TILE_BASE_W-1:0] tile_base;
    logic [2:0]        fetch_line;
    logic [ADDR_W-1:0] plane_addr;
    logic [2:0]        sh;
    logic [1:0]        ci;

    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign mem_we = o_pop && (i_op.kind == K_WRITE);

    always_comb begin
        attr = i_cfg.colour_mode ? r_rd_b : 8'h00;
        if (i_cfg.unsigned_tile_data) tile_base = {1'b0, r_rd_a, 4'b0};
        else tile_base = SIGNED_BASE + {r_rd_a[7], r_rd_a, 4'b0};
        fetch_line = attr[ATTR_VFLIP_BIT] ? (r_op.line ^ LINE_MASK) : r_op.line;
        // tile base is 16-byte aligned, so the line offset just ORs in
        plane_addr = {attr[ATTR_BANK_BIT], tile_base} | {10'b0, fetch_line, 1'b0};

        rd_en = 1'b0;
        ra_a  = i_op.addr;
        ra_b  = i_op.addr | BANK_OFFSET;
        unique case (r_state)
            S_IDLE: rd_en = o_pop && (i_op.kind == K_RENDER);
            S_TILE: begin
                rd_en = 1'b1;
                ra_a  = plane_addr;
                ra_b  = plane_addr | ADDR_W'(1);
            end
            S_PIX:   rd_en = 1'b0;
            default: rd_en = 1'b0;
        endcase

        sh = r_attr[ATTR_HFLIP_BIT] ? r_px : ~r_px;
        ci = {r_rd_b[sh], r_rd_a[sh]};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_vram[i_op.addr] <= i_op.data;
        if (rd_en) begin
            r_rd_a <= r_vram[ra_a];
            r_rd_b <= r_vram[ra_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_px    <= '0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && (i_op.kind == K_RENDER)) begin
                        r_op    <= i_op;
                        r_state <= S_TILE;
                    end
                end
                S_TILE: begin
                    r_attr  <= attr;
                    r_px    <= '0;
                    r_state <= S_PIX;
                end
                S_PIX: begin
                    o_valid          <= 1'b1;
                    o_pixel_x        <= {r_op.col, r_px};
                    o_pixel_y        <= {r_op.row, r_op.line};
                    o_colour_index   <= ci;
                    o_palette_number <= r_attr[2:0];
                    o_last_pixel     <= (r_px == 3'd7);
                    r_px             <= r_px + 3'd1;
                    if (r_px == 3'd7) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/tilemap_pixel_fetch_core.sv */
// Channel   Direction  Handshake                Payload
// item in   input      start & !busy            i_cmd, i_mem_address, i_mem_data,
//                                                i_map_select, i_tile_column/row/line
// pixel out output     o_pixel_valid (1 cycle)  o_pixel_x, o_pixel_y, o_colour_index,
//                                                o_palette_number, o_last_pixel
// config    input      i_cfg_we                 i_cfg_index, i_cfg_data
//
// A write item is done in the back end's idle state, as it is popped. A render item
// reads map/attribute bytes in the idle state and plane bytes in the tile state
// (both on the two read ports of the single video memory), then one pixel per cycle.
// Pixels appear in the cycle after they are formed, back to back, then a gap.
// busy rises when the item queue is full. Video memory is not cleared by reset.
// Reset (i_rst_n low, synchronous) empties the queue and idles the back end.
// The pixel receiver cannot stall; every strobe carries one pixel.
`default_nettype none

module tilemap_pixel_fetch_core
    import tpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = TPF_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cmd,
    input  wire logic [13:0] i_mem_address,
    input  wire logic [7:0]  i_mem_data,
    input  wire logic        i_map_select,
    input  wire logic [4:0]  i_tile_column,
    input  wire logic [4:0]  i_tile_row,
    input  wire logic [2:0]  i_tile_line,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic        i_cfg_data,
    output logic             o_pixel_valid,
    output logic [7:0]       o_pixel_x,
    output logic [7:0]       o_pixel_y,
    output logic [1:0]       o_colour_index,
    output logic [2:0]       o_palette_number,
    output logic             o_last_pixel
);

    t_cfg r_cfg;
    t_op  push_op, head_op;
    logic push, pop, q_full, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.colour_mode        <= 1'b0;
            r_cfg.unsigned_tile_data <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COLOUR_MODE:        r_cfg.colour_mode        <= i_cfg_data;
                CFG_UNSIGNED_TILE_DATA: r_cfg.unsigned_tile_data <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tpf_front u_front (
        .start         (start),
        .i_cmd         (i_cmd),
        .i_mem_address (i_mem_address),
        .i_mem_data    (i_mem_data),
        .i_map_select  (i_map_select),
        .i_tile_column (i_tile_column),
        .i_tile_row    (i_tile_row),
        .i_tile_line   (i_tile_line),
        .i_queue_full  (q_full),
        .busy          (busy),
        .o_push        (push),
        .o_op          (push_op)
    );

    tpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_op    (head_op),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tpf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_op             (head_op),
        .i_empty          (q_empty),
        .o_pop            (pop),
        .o_valid          (o_pixel_valid),
        .o_pixel_x        (o_pixel_x),
        .o_pixel_y        (o_pixel_y),
        .o_colour_index   (o_colour_index),
        .o_palette_number (o_palette_number),
        .o_last_pixel     (o_last_pixel)
    );

    // a line's eight pixels come out in consecutive cycles
    a_pixels_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pixel_valid && !o_last_pixel |=> o_pixel_valid)
        else $error("pixel run broken before last pixel");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pixel_valid && o_last_pixel |=> !o_pixel_valid)
        else $error("pixel strobe right after last pixel");

    a_run_starts_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_pixel_valid) |-> (o_pixel_x[2:0] == 3'd0))
        else $error("pixel run does not start at tile column origin");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench
    import tpf_pkg::*;
();

    localparam int SETTLE_CYCLES = 20;
    localparam int SEG_ITEMS     = 50;
    // per segment: colour_mode / unsigned_tile_data, bit i = segment i
    localparam logic [3:0] SEG_COLOUR   = 4'b0011;
    localparam logic [3:0] SEG_UNSIGNED = 4'b1001;

    typedef struct {
        t_kind       cmd;
        logic [13:0] addr;
        logic [7:0]  data;
        logic        map;
        logic [4:0]  col;
        logic [4:0]  row;
        logic [2:0]  line;
    } t_fetch_item;

    typedef struct {
        logic [7:0] x;
        logic [7:0] y;
        logic [1:0] ci;
        logic [2:0] pal;
        logic       last;
    } t_pixel;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_fetch_item item;
        logic        cfg_index;
        logic        cfg_value;
        bit          chk;       // colours typed in below instead of predicted
        logic [15:0] ci_word;   // pixel 0 in the top two bits
        logic [2:0]  pal;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic        i_cmd         = 1'b0;
    logic [13:0] i_mem_address = '0;
    logic [7:0]  i_mem_data    = '0;
    logic        i_map_select  = 1'b0;
    logic [4:0]  i_tile_column = '0;
    logic [4:0]  i_tile_row    = '0;
    logic [2:0]  i_tile_line   = '0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = 1'b0;
    logic        i_cfg_data    = 1'b0;
    logic        busy;
    logic        o_pixel_valid;
    logic [7:0]  o_pixel_x;
    logic [7:0]  o_pixel_y;
    logic [1:0]  o_colour_index;
    logic [2:0]  o_palette_number;
    logic        o_last_pixel;

    tilemap_pixel_fetch_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_mem_address   (i_mem_address),
        .i_mem_data      (i_mem_data),
        .i_map_select    (i_map_select),
        .i_tile_column   (i_tile_column),
        .i_tile_row      (i_tile_row),
        .i_tile_line     (i_tile_line),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_pixel_valid   (o_pixel_valid),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_colour_index  (o_colour_index),
        .o_palette_number(o_palette_number),
        .o_last_pixel    (o_last_pixel)
    );

    // shadow of the block's video memory and registers
    logic [7:0] vram_copy [0:16383];
    bit         vram_written [0:16383];
    logic       cfg_colour   = 1'b0;
    logic       cfg_unsigned = 1'b1;

    t_pixel   pending_pixels[$];
    t_dir_row directed_rows[$];

    int fail_count     = 0;
    int items_sent     = 0;
    int renders_sent   = 0;
    int pixels_checked = 0;
    int idle_pct       = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [13:0] tile_data_addr(logic [7:0] tile, logic [7:0] attr);
        logic [13:0] a;
        logic [12:0] sum;
        if (cfg_unsigned) begin
            a = {2'b00, tile, 4'b0000};
        end else begin
            sum = SIGNED_BASE + {tile[7], tile, 4'b0000};
            a = {1'b0, sum};
        end
        if (attr[ATTR_BANK_BIT])
            a = a | BANK_OFFSET;
        return a;
    endfunction

    function automatic logic [13:0] map_address(t_fetch_item it);
        return (it.map ? MAP_BASE_HIGH : MAP_BASE_LOW) + {4'b0000, it.row, it.col};
    endfunction

    function automatic logic [7:0] attr_of(t_fetch_item it);
        return cfg_colour ? vram_copy[map_address(it) | BANK_OFFSET] : 8'h00;
    endfunction

    function automatic logic [13:0] plane_address(t_fetch_item it);
        logic [7:0] attr;
        logic [2:0] fl;
        attr = attr_of(it);
        fl = attr[ATTR_VFLIP_BIT] ? (it.line ^ LINE_MASK) : it.line;
        return tile_data_addr(vram_copy[map_address(it)], attr) + {10'b0, fl, 1'b0};
    endfunction

    // update the shadow memory, or queue the eight pixels a render produces
    function automatic void record_item(t_fetch_item it);
        logic [7:0]  attr;
        logic [13:0] pa;
        logic [7:0]  lo;
        logic [7:0]  hi;
        int unsigned sh;
        t_pixel      px;
        if (it.cmd == K_WRITE) begin
            vram_copy[it.addr]    = it.data;
            vram_written[it.addr] = 1'b1;
        end else begin
            attr = attr_of(it);
            pa = plane_address(it);
            lo = vram_copy[pa];
            hi = vram_copy[pa + 14'd1];
            for (int x = 0; x < 8; x++) begin
                sh = attr[ATTR_HFLIP_BIT] ? x : 7 - x;
                px.x    = {it.col, 3'(x)};
                px.y    = {it.row, it.line};
                px.ci   = {hi[sh], lo[sh]};
                px.pal  = attr[2:0];
                px.last = (x == 7);
                pending_pixels.push_back(px);
            end
        end
    endfunction

    function automatic t_fetch_item random_item(t_kind cmd);
        t_fetch_item it;
        it.cmd  = cmd;
        it.addr = 14'($urandom);
        it.data = 8'($urandom);
        it.map  = 1'($urandom);
        it.col  = 5'($urandom);
        it.row  = 5'($urandom);
        it.line = 3'($urandom);
        return it;
    endfunction

    task automatic send_item(t_fetch_item it, bit predict);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_cmd         <= it.cmd;
        i_mem_address <= it.addr;
        i_mem_data    <= it.data;
        i_map_select  <= it.map;
        i_tile_column <= it.col;
        i_tile_row    <= it.row;
        i_tile_line   <= it.line;
        start         <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        if (it.cmd == K_RENDER)
            renders_sent++;
        if (predict)
            record_item(it);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        // a trailing write may still be in the queue
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(logic index, logic value);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_COLOUR_MODE)
            cfg_colour = value;
        else
            cfg_unsigned = value;
    endtask

    task automatic ensure_written(logic [13:0] addr);
        t_fetch_item it;
        if (!vram_written[addr]) begin
            it = random_item(K_WRITE);
            it.addr = addr;
            send_item(it, 1'b1);
        end
    endtask

    // fill whatever the render will read, then issue it
    task automatic issue_render();
        t_fetch_item it;
        logic [13:0] pa;
        it = random_item(K_RENDER);
        ensure_written(map_address(it));
        if (cfg_colour)
            ensure_written(map_address(it) | BANK_OFFSET);
        pa = plane_address(it);
        ensure_written(pa);
        ensure_written(pa + 14'd1);
        send_item(it, 1'b1);
    endtask

    function automatic t_dir_row blank_row();
        t_dir_row r;
        r.kind      = ROW_ITEM;
        r.item.cmd  = K_WRITE;
        r.item.addr = '0;
        r.item.data = '0;
        r.item.map  = 1'b0;
        r.item.col  = '0;
        r.item.row  = '0;
        r.item.line = '0;
        r.cfg_index = 1'b0;
        r.cfg_value = 1'b0;
        r.chk       = 1'b0;
        r.ci_word   = '0;
        r.pal       = '0;
        return r;
    endfunction

    function automatic t_dir_row wr_row(logic [13:0] addr, logic [7:0] data);
        t_dir_row r;
        r = blank_row();
        r.kind = ROW_ITEM;
        r.item.cmd  = K_WRITE;
        r.item.addr = addr;
        r.item.data = data;
        return r;
    endfunction

    function automatic t_dir_row render_row(logic map, logic [4:0] col, logic [4:0] row,
                                            logic [2:0] line, bit chk,
                                            logic [15:0] ci_word, logic [2:0] pal);
        t_dir_row r;
        r = blank_row();
        r.kind = ROW_ITEM;
        r.item.cmd  = K_RENDER;
        r.item.map  = map;
        r.item.col  = col;
        r.item.row  = row;
        r.item.line = line;
        r.chk     = chk;
        r.ci_word = ci_word;
        r.pal     = pal;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(logic index, logic value);
        t_dir_row r;
        r = blank_row();
        r.kind      = ROW_CFG;
        r.cfg_index = index;
        r.cfg_value = value;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_pixel_valid) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel x=%0d y=%0d", o_pixel_x, o_pixel_y);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (o_pixel_x !== want.x) begin
                    $error("pixel_x expected %0d got %0d", want.x, o_pixel_x);
                    fail_count++;
                end
                if (o_pixel_y !== want.y) begin
                    $error("pixel_y expected %0d got %0d", want.y, o_pixel_y);
                    fail_count++;
                end
                if (o_colour_index !== want.ci) begin
                    $error("colour_index expected %0d got %0d", want.ci, o_colour_index);
                    fail_count++;
                end
                if (o_palette_number !== want.pal) begin
                    $error("palette_number expected %0d got %0d", want.pal, o_palette_number);
                    fail_count++;
                end
                if (o_last_pixel !== want.last) begin
                    $error("last_pixel expected %0d got %0d", want.last, o_last_pixel);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_pixel      px;
        t_fetch_item it;
        int          seg_first;
        int          drain_at;
        int          pick;
        bit          drained;

        // reset registers: no attributes, unsigned tile data
        directed_rows.push_back(wr_row(14'h3FFF, 8'h00));
        directed_rows.push_back(wr_row(14'h1800, 8'h00));
        directed_rows.push_back(wr_row(14'h0000, 8'hF0));
        directed_rows.push_back(wr_row(14'h0001, 8'hCC));
        directed_rows.push_back(render_row(1'b0, 5'd0, 5'd0, 3'd0, 1'b1,
                                           16'b11_11_01_01_10_10_00_00, 3'd0));
        directed_rows.push_back(wr_row(14'h1FFF, 8'hFF));
        directed_rows.push_back(wr_row(14'h0FFE, 8'hAA));
        directed_rows.push_back(wr_row(14'h0FFF, 8'h55));
        directed_rows.push_back(render_row(1'b1, 5'd31, 5'd31, 3'd7, 1'b1,
                                           16'b01_10_01_10_01_10_01_10, 3'd0));
        // signed addressing: tile 0xFF lands on the same bytes, tile 0 moves to 0x1000
        directed_rows.push_back(cfg_row(CFG_UNSIGNED_TILE_DATA, 1'b0));
        directed_rows.push_back(render_row(1'b1, 5'd31, 5'd31, 3'd7, 1'b0, '0, '0));
        directed_rows.push_back(wr_row(14'h1000, 8'h0F));
        directed_rows.push_back(wr_row(14'h1001, 8'hFF));
        directed_rows.push_back(render_row(1'b0, 5'd0, 5'd0, 3'd0, 1'b1,
                                           16'b10_10_10_10_11_11_11_11, 3'd0));
        // colour mode: bank 1, both flips, palette 7
        directed_rows.push_back(cfg_row(CFG_COLOUR_MODE, 1'b1));
        directed_rows.push_back(wr_row(14'h3800, 8'h6F));
        directed_rows.push_back(wr_row(14'h300E, 8'h01));
        directed_rows.push_back(wr_row(14'h300F, 8'h80));
        directed_rows.push_back(render_row(1'b0, 5'd0, 5'd0, 3'd0, 1'b1,
                                           16'b01_00_00_00_00_00_00_10, 3'd7));
        // attribute bits 4 and 7 alone change nothing
        directed_rows.push_back(wr_row(14'h3800, 8'h90));
        directed_rows.push_back(render_row(1'b0, 5'd0, 5'd0, 3'd0, 1'b1,
                                           16'b10_10_10_10_11_11_11_11, 3'd0));
        directed_rows.push_back(render_row(1'b1, 5'd31, 5'd31, 3'd7, 1'b0, '0, '0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_CFG) begin
                write_config(directed_rows[n].cfg_index, directed_rows[n].cfg_value);
            end else begin
                it = directed_rows[n].item;
                send_item(it, !directed_rows[n].chk);
                if (it.cmd == K_WRITE) begin
                    record_item(it);
                end else if (directed_rows[n].chk) begin
                    for (int x = 0; x < 8; x++) begin
                        px.x    = {it.col, 3'(x)};
                        px.y    = {it.row, it.line};
                        px.ci   = directed_rows[n].ci_word[15 - 2 * x -: 2];
                        px.pal  = directed_rows[n].pal;
                        px.last = (x == 7);
                        pending_pixels.push_back(px);
                    end
                end
            end
        end

        for (int seg = 0; seg < 4; seg++) begin
            write_config(CFG_COLOUR_MODE, SEG_COLOUR[seg]);
            write_config(CFG_UNSIGNED_TILE_DATA, SEG_UNSIGNED[seg]);
            case (seg)
                0:       idle_pct = 38;
                1:       idle_pct = 47;
                default: idle_pct = 0;
            endcase
            seg_first = items_sent;
            drain_at  = $urandom_range(10, 40);
            drained   = 1'b0;
            while (items_sent - seg_first < SEG_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 65) begin
                    issue_render();
                end else begin
                    it = random_item(K_WRITE);
                    if (pick >= 95)
                        it.addr[12:11] = 2'b11;             // map or attribute entry
                    else if (pick >= 85)
                        it.addr[12:0] = 13'($urandom_range(14'h17FF));  // tile data
                    send_item(it, 1'b1);
                end
                if (!drained && items_sent - seg_first >= drain_at) begin
                    wait_quiet();
                    drained = 1'b1;
                end
            end
        end

        wait_quiet();

        $display("covered %0d items, %0d renders, %0d pixels checked",
                 items_sent, renders_sent, pixels_checked);
        $display("all four register settings, sender gaps, back-to-back items, mid-run drains");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
